/* sv/smlse_pkg.sv */
// Shared types and constants for the softmax / log-sum-exp block.
// Used by smlse_mul60, smlse_div and softmax_log_sum_exp; no dependencies.
package smlse_pkg;

  localparam int MAX_LENGTH_DEF = 32;
  localparam int SCORE_W        = 32;
  localparam int SUM_W          = 24;   // Q8.16 sum, kept with headroom
  localparam int E_W            = 17;   // exp result, Q0.16 up to 1.0
  localparam int LN_W           = 20;   // ln(sum) in Q16.16, below 6.0
  localparam int DVS_W          = 24;
  localparam int STEP_W         = 7;

  localparam logic [63:0] FIX_ONE   = 64'h1000_0000_0000_0000;   // 1.0 at 60 fraction bits
  localparam logic [63:0] HALF_AT16 = 64'h0000_0800_0000_0000;   // rounding half at 16 bits
  localparam logic [63:0] Z_THIRD   = 64'h0555_5555_5555_5555;   // floor(1/3) at 60 fraction bits
  localparam logic [32:0] EXP_LIMIT = 33'd786432;                 // 12.0 in Q16.16

  localparam logic [STEP_W-1:0] STEPS_FULL = 7'd64;   // plain 64-bit quotient
  localparam logic [STEP_W-1:0] STEPS_FRAC = 7'd60;   // 60-bit fraction of num/den

  // request into the shared 60-bit fraction multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // request into the shared long divider
  typedef struct packed {
    logic              start;
    logic [DVS_W-1:0]  rem0;
    logic [63:0]       dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

/* sv/softmax_log_sum_exp.sv */
// Streaming softmax with log-sum-exp. While the block is idle, scores are taken
// one per cycle into the score memory while the running maximum is tracked. The
// request marked final starts three passes: exp(s - max) for each stored score
// into a second memory with the Q8.16 sum, one probability floor(e*2^16/sum)
// per score in load order, and last max + ln(sum). Throughput is set by the
// shared multiplier and the bit-serial divider: an exp needs a multiply and a
// divide per Taylor term plus 4 squarings, each probability one divide, and the
// log a divide and a multiply per series term over two series. No requests are
// taken while a vector is processed.
// Depends on smlse_pkg, smlse_mul60 and smlse_div.
module softmax_log_sum_exp #(
  parameter int MAX_LENGTH = smlse_pkg::MAX_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] score_i,
  input  logic        final_score_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic        result_kind_o,
  output logic        vector_overflowed_o,
  output logic        end_of_run_o
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int E_W   = smlse_pkg::E_W;
  localparam int SUM_W = smlse_pkg::SUM_W;
  localparam int LN_W  = smlse_pkg::LN_W;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_P1_RD   = 5'd1;
  localparam logic [4:0] ST_P1_DIFF = 5'd2;
  localparam logic [4:0] ST_E_MUL   = 5'd3;
  localparam logic [4:0] ST_E_DIV   = 5'd4;
  localparam logic [4:0] ST_E_SQ    = 5'd5;
  localparam logic [4:0] ST_P1_WR   = 5'd6;
  localparam logic [4:0] ST_P2_RD   = 5'd7;
  localparam logic [4:0] ST_P2_DIV  = 5'd8;
  localparam logic [4:0] ST_P2_WAIT = 5'd9;
  localparam logic [4:0] ST_P2_OUT  = 5'd10;
  localparam logic [4:0] ST_L_START = 5'd11;
  localparam logic [4:0] ST_L_Z     = 5'd12;
  localparam logic [4:0] ST_L_Z2    = 5'd13;
  localparam logic [4:0] ST_L_CHK   = 5'd14;
  localparam logic [4:0] ST_L_TD    = 5'd15;
  localparam logic [4:0] ST_L_P     = 5'd16;
  localparam logic [4:0] ST_L_FIN   = 5'd17;
  localparam logic [4:0] ST_L_OUT   = 5'd18;

  logic [4:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, idx_q, idx_d;
  logic signed [31:0]      max_q, max_d;
  logic                    ovf_q, ovf_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [63:0]             y_q, y_d, pos_q, pos_d, neg_q, neg_d;
  logic [5:0]              n_q, n_d;
  logic [1:0]              k_q, k_d;
  logic [E_W-1:0]          e_q, e_d;
  logic [2:0]              norm_q, norm_d;
  logic [SUM_W-1:0]        num_q, num_d, den_q, den_d;
  logic [63:0]             z2_q, z2_d, p_q, p_d, acc_q, acc_d, a1_q, a1_d;
  logic [6:0]              j_q, j_d;
  logic                    which_q, which_d, zero_q, zero_d;
  logic [LN_W-1:0]         lnq_q, lnq_d;

  logic                    out_valid_q;
  logic signed [31:0]      res_value_q;
  logic                    res_kind_q, res_ovf_q, res_eor_q;
  logic                    out_free, out_load;
  logic signed [31:0]      out_value;
  logic                    out_kind;

  // memories
  logic [31:0]             score_mem [MAX_LENGTH];
  logic [E_W-1:0]          e_mem [MAX_LENGTH];
  logic [31:0]             score_rd_q;
  logic [E_W-1:0]          e_rd_q;
  logic                    score_we, e_we;

  smlse_pkg::mul_req_t     mul_req;
  smlse_pkg::div_req_t     div_req;
  logic                    mul_done, div_done;
  logic [63:0]             mul_res, div_quot;

  logic                    accept;
  logic signed [32:0]      diff;
  logic [63:0]             v_new, pos_new, neg_new, rnd, ln_acc;
  logic [2:0]              nn;
  logic [SUM_W-1:0]        pw;
  logic signed [32:0]      total;

  smlse_mul60 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  smlse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // score memory: written at load, read at the pass index
  always_ff @(posedge clk_i) begin
    if (score_we) begin
      score_mem[cnt_q[IDX_W-1:0]] <= score_i;
    end
    score_rd_q <= score_mem[idx_q[IDX_W-1:0]];
  end

  // exp memory: written in the first pass, read in the second
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      e_mem[idx_q[IDX_W-1:0]] <= e_q;
    end
    e_rd_q <= e_mem[idx_q[IDX_W-1:0]];
  end

  // normalization of the sum for the log: sum = m * 2^nn, m in [1,2)
  always_comb begin
    nn = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (nn == 3'(i) && (sum_q >> (17 + i)) != '0) begin
        nn = nn + 3'd1;
      end
    end
    pw = SUM_W'(1) << (5'd16 + {2'd0, nn});
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    max_d    = max_q;
    ovf_d    = ovf_q;
    sum_d    = sum_q;
    y_d      = y_q;
    pos_d    = pos_q;
    neg_d    = neg_q;
    n_d      = n_q;
    k_d      = k_q;
    e_d      = e_q;
    norm_d   = norm_q;
    num_d    = num_q;
    den_d    = den_q;
    z2_d     = z2_q;
    p_d      = p_q;
    acc_d    = acc_q;
    a1_d     = a1_q;
    j_d      = j_q;
    which_d  = which_q;
    zero_d   = zero_q;
    lnq_d    = lnq_q;
    score_we = 1'b0;
    e_we     = 1'b0;
    out_load = 1'b0;
    out_value = '0;
    out_kind  = 1'b0;
    mul_req  = '0;
    div_req  = '0;
    diff     = {max_q[31], max_q} - {score_rd_q[31], score_rd_q};
    pos_new  = pos_q;
    neg_new  = neg_q;
    v_new    = '0;
    rnd      = mul_res + smlse_pkg::HALF_AT16;
    ln_acc   = ({61'd0, norm_q} * a1_q) + acc_q + smlse_pkg::HALF_AT16;
    total    = max_q + $signed({13'd0, lnq_q});

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_q < CNT_W'(MAX_LENGTH)) begin
            score_we = 1'b1;
            cnt_d    = cnt_q + 1'b1;
            if (score_i > max_q) begin
              max_d = score_i;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (final_score_i) begin
            idx_d   = '0;
            sum_d   = '0;
            state_d = (cnt_d == '0) ? ST_L_START : ST_P1_RD;
          end
        end
      end

      ST_P1_RD: state_d = ST_P1_DIFF;

      // start the Taylor series of exp(-d/16), or skip far scores
      ST_P1_DIFF: begin
        if (diff >= $signed(smlse_pkg::EXP_LIMIT)) begin
          e_d     = '0;
          state_d = ST_P1_WR;
        end else begin
          y_d       = {4'd0, diff[19:0], 40'd0};
          pos_d     = smlse_pkg::FIX_ONE;
          neg_d     = '0;
          n_d       = 6'd1;
          mul_req.start = 1'b1;
          mul_req.a     = smlse_pkg::FIX_ONE;
          mul_req.b     = {4'd0, diff[19:0], 40'd0};
          state_d   = ST_E_MUL;
        end
      end

      ST_E_MUL: begin
        if (mul_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_res;
          div_req.divisor  = {18'd0, n_q};
          div_req.steps    = smlse_pkg::STEPS_FULL;
          state_d          = ST_E_DIV;
        end
      end

      // add the new term; stop on a zero term or after the last order
      ST_E_DIV: begin
        if (div_done) begin
          if (n_q[0]) begin
            neg_new = neg_q + div_quot;
          end else begin
            pos_new = pos_q + div_quot;
          end
          if (div_quot == '0 || n_q == 6'd63) begin
            v_new = (div_quot == '0) ? (pos_q - neg_q) : (pos_new - neg_new);
            k_d   = 2'd0;
            mul_req.start = 1'b1;
            mul_req.a     = v_new;
            mul_req.b     = v_new;
            state_d = ST_E_SQ;
          end else begin
            n_d = n_q + 6'd1;
            mul_req.start = 1'b1;
            mul_req.a     = div_quot;
            mul_req.b     = y_q;
            state_d = ST_E_MUL;
          end
          pos_d = pos_new;
          neg_d = neg_new;
        end
      end

      // four squarings, then round to Q0.16
      ST_E_SQ: begin
        if (mul_done) begin
          if (k_q == 2'd3) begin
            e_d     = E_W'(rnd >> 44);
            state_d = ST_P1_WR;
          end else begin
            k_d = k_q + 2'd1;
            mul_req.start = 1'b1;
            mul_req.a     = mul_res;
            mul_req.b     = mul_res;
          end
        end
      end

      ST_P1_WR: begin
        e_we  = 1'b1;
        sum_d = sum_q + SUM_W'(e_q);
        if (idx_q == cnt_q - 1'b1) begin
          idx_d   = '0;
          state_d = ST_P2_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_P1_RD;
        end
      end

      ST_P2_RD: state_d = ST_P2_DIV;

      ST_P2_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {31'd0, e_rd_q, 16'd0};
        div_req.divisor  = sum_q;
        div_req.steps    = smlse_pkg::STEPS_FULL;
        state_d          = ST_P2_WAIT;
      end

      ST_P2_WAIT: if (div_done) state_d = ST_P2_OUT;

      ST_P2_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_value = (sum_q == '0) ? '0 : div_quot[31:0];
          out_kind  = 1'b0;
          if (idx_q == cnt_q - 1'b1) begin
            state_d = ST_L_START;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_P2_RD;
          end
        end
      end

      // ln(sum): first 2*atanh(1/3) for ln2, then the mantissa term
      ST_L_START: begin
        if (sum_q < SUM_W'(65536)) begin
          zero_d  = 1'b1;
          state_d = ST_L_OUT;
        end else begin
          zero_d  = 1'b0;
          norm_d  = nn;
          num_d   = sum_q - pw;
          den_d   = sum_q + pw;
          which_d = 1'b0;
          // z = 1/3 is a fixed fraction, no division needed
          p_d     = smlse_pkg::Z_THIRD;
          mul_req.start = 1'b1;
          mul_req.a     = smlse_pkg::Z_THIRD;
          mul_req.b     = smlse_pkg::Z_THIRD;
          state_d = ST_L_Z2;
        end
      end

      ST_L_Z: begin
        if (div_done) begin
          p_d = div_quot;
          mul_req.start = 1'b1;
          mul_req.a     = div_quot;
          mul_req.b     = div_quot;
          state_d = ST_L_Z2;
        end
      end

      ST_L_Z2: begin
        if (mul_done) begin
          z2_d    = mul_res;
          j_d     = '0;
          acc_d   = '0;
          state_d = ST_L_CHK;
        end
      end

      // series term loop, ends on a zero power or after 64 terms
      ST_L_CHK: begin
        if (p_q == '0 || j_q == 7'd64) begin
          if (!which_q) begin
            a1_d    = acc_q << 1;
            which_d = 1'b1;
            div_req.start   = 1'b1;
            div_req.rem0    = num_q;
            div_req.divisor = den_q;
            div_req.steps   = smlse_pkg::STEPS_FRAC;
            state_d = ST_L_Z;
          end else begin
            acc_d   = acc_q << 1;
            state_d = ST_L_FIN;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = p_q;
          div_req.divisor  = {16'd0, j_q, 1'b1};
          div_req.steps    = smlse_pkg::STEPS_FULL;
          state_d = ST_L_TD;
        end
      end

      ST_L_TD: begin
        if (div_done) begin
          acc_d = acc_q + div_quot;
          mul_req.start = 1'b1;
          mul_req.a     = p_q;
          mul_req.b     = z2_q;
          state_d = ST_L_P;
        end
      end

      ST_L_P: begin
        if (mul_done) begin
          p_d     = mul_res;
          j_d     = j_q + 7'd1;
          state_d = ST_L_CHK;
        end
      end

      ST_L_FIN: begin
        lnq_d   = LN_W'(ln_acc >> 44);
        state_d = ST_L_OUT;
      end

      // total with saturation (zero for a sum below 1.0), then clear for the next vector
      ST_L_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = 1'b1;
          if (zero_q) begin
            out_value = '0;
          end else if (total > 33'sd2147483647) begin
            out_value = 32'sh7FFF_FFFF;
          end else begin
            out_value = total[31:0];
          end
          cnt_d   = '0;
          max_d   = 32'sh8000_0000;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      max_q       <= 32'sh8000_0000;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      max_q   <= max_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    y_q     <= y_d;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
    n_q     <= n_d;
    k_q     <= k_d;
    e_q     <= e_d;
    norm_q  <= norm_d;
    num_q   <= num_d;
    den_q   <= den_d;
    z2_q    <= z2_d;
    p_q     <= p_d;
    acc_q   <= acc_d;
    a1_q    <= a1_d;
    j_q     <= j_d;
    which_q <= which_d;
    zero_q  <= zero_d;
    lnq_q   <= lnq_d;
    if (out_load) begin
      res_value_q <= out_value;
      res_kind_q  <= out_kind;
      res_ovf_q   <= ovf_q;
      res_eor_q   <= out_kind;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_value_o      = res_value_q;
  assign result_kind_o       = res_kind_q;
  assign vector_overflowed_o = res_ovf_q;
  assign end_of_run_o        = res_eor_q;

endmodule

/* sv/smlse_mul60.sv */
// Multi-cycle (a*b) >> 60 with truncation, built on one 32x32 multiplier.
// Depends on smlse_pkg for the request type.
module smlse_mul60 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smlse_pkg::mul_req_t req_i,
  output logic                done_o,
  output logic [63:0]         res_o
);

  logic [63:0] a_q, b_q, prod_q, mid_q, res_q;
  logic [2:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] opx, opy;
  logic [63:0] prod_d;

  // operand select: step bit 0 picks the high half of a, bit 1 that of b
  always_comb begin
    opx    = step_q[0] ? a_q[63:32] : a_q[31:0];
    opy    = step_q[1] ? b_q[63:32] : b_q[31:0];
    prod_d = {32'd0, opx} * {32'd0, opy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 3'd1;
      end
    end
  end

  // partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      prod_q <= prod_d;
      case (step_q)
        3'd1:      mid_q <= prod_q >> 32;
        3'd2, 3'd3: mid_q <= mid_q + prod_q;
        3'd4:      res_q <= (prod_q << 4) + (mid_q >> 28);
        default:   mid_q <= mid_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/smlse_div.sv */
// Restoring long divider, one quotient bit per cycle, with a preset remainder.
// Depends on smlse_pkg for the request type and widths.
module smlse_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smlse_pkg::div_req_t req_i,
  output logic                done_o,
  output logic [63:0]         quot_o
);

  logic [smlse_pkg::DVS_W-1:0]  r_q, dvs_q;
  logic [63:0]                  dvd_q, q_q;
  logic [smlse_pkg::STEP_W-1:0] cnt_q;
  logic                         busy_q, done_q;
  logic [smlse_pkg::DVS_W:0]    r_sh, r_sub;
  logic                         ge;

  always_comb begin
    r_sh  = {r_q, dvd_q[63]};
    ge    = r_sh >= {1'b0, dvs_q};
    r_sub = r_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == smlse_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-subtract datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= req_i.rem0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      q_q   <= '0;
    end else if (busy_q) begin
      r_q   <= ge ? r_sub[smlse_pkg::DVS_W-1:0] : r_sh[smlse_pkg::DVS_W-1:0];
      dvd_q <= dvd_q << 1;
      q_q   <= {q_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

/* verif/softmax_log_sum_exp_test.sv */
// Self-checking bench for softmax_log_sum_exp: drives score vectors, predicts
// probabilities and log-sum-exp totals in fixed point, and checks each result.
// Depends on smlse_pkg and softmax_log_sum_exp.
`timescale 1ns / 100ps

module softmax_log_sum_exp_test;

  localparam int unsigned CAP = smlse_pkg::MAX_LENGTH_DEF;
  localparam logic [63:0] ONE_60  = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_16 = 64'h0000_0800_0000_0000;
  localparam longint EXP_CUTOFF = 64'd786432;
  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] score;
    logic               last;
    bit                 pause;   // sender waits for all results here
  } score_req_t;

  typedef struct {
    logic [31:0] value;
    logic        kind;
    logic        ovf;
    logic        eor;
  } softmax_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] score_i = '0;
  logic final_score_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic result_kind_o;
  logic vector_overflowed_o;
  logic end_of_run_o;

  score_req_t   pending_scores[$];
  softmax_res_t expected_results[$];

  // shadow of the block's vector state
  longint      shadow_store[CAP];
  int unsigned shadow_count = 0;
  longint      shadow_max = INT32_LO;
  bit          shadow_ovf = 1'b0;

  int unsigned n_offered = 0, n_taken = 0, n_results = 0;
  int unsigned n_vectors = 0, n_ovf_vectors = 0, errors = 0;
  int unsigned burst_left = 1, gap_left = 0;
  int unsigned hold_left = 0, run_left = 0;
  bit          held = 1'b0, run_stall = 1'b0;

  softmax_log_sum_exp i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // product of two 60-bit fractions, truncated
  function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[123:60];
  endfunction

  // exp(-d) for Q16.16 d below 12.0, Q0.16 result
  function automatic logic [63:0] exp_neg(logic [63:0] d);
    logic [63:0] y, pos, neg, t, v;
    y = d << 40;
    pos = ONE_60;
    neg = '0;
    t = ONE_60;
    for (int n = 1; n < 64; n++) begin
      t = frac_mul(t, y) / n;
      if (t == 0) break;
      if (n % 2 == 1) neg += t;
      else pos += t;
    end
    v = pos - neg;
    for (int k = 0; k < 4; k++) v = frac_mul(v, v);
    return (v + HALF_16) >> 44;
  endfunction

  // 2*atanh(num/den) at 60 fraction bits
  function automatic logic [63:0] twice_atanh(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    logic [63:0] z, z2, p, acc;
    q = ({64'b0, num} << 60) / {64'b0, den};
    z = q[63:0];
    z2 = frac_mul(z, z);
    p = z;
    acc = '0;
    for (int j = 0; j < 64 && p != 0; j++) begin
      acc += p / (2 * j + 1);
      p = frac_mul(p, z2);
    end
    return acc * 2;
  endfunction

  // ln(s / 2^16), Q16.16
  function automatic longint ln_sum(logic [63:0] s);
    logic [63:0] n, p, acc;
    n = 0;
    while (n < 7 && (s >> (17 + n)) != 0) n++;
    p = 64'd1 << (16 + n);
    acc = n * twice_atanh(64'd1, 64'd3) + twice_atanh(s - p, s + p);
    return longint'((acc + HALF_16) >> 44);
  endfunction

  function automatic logic [63:0] exp_of(longint s, longint mx);
    logic [63:0] d;
    d = 64'(mx - s);
    return (d >= EXP_CUTOFF) ? 64'd0 : exp_neg(d);
  endfunction

  // update the shadow state with one accepted score, queue results on final
  task automatic predict_softmax(logic signed [31:0] score, logic last);
    logic [63:0] sum, e;
    longint total;
    softmax_res_t r;
    if (shadow_count < CAP) begin
      shadow_store[shadow_count] = score;
      shadow_count++;
      if (longint'(score) > shadow_max) shadow_max = score;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (last) begin
      sum = '0;
      for (int i = 0; i < shadow_count; i++) sum += exp_of(shadow_store[i], shadow_max);
      for (int i = 0; i < shadow_count; i++) begin
        e = exp_of(shadow_store[i], shadow_max);
        r.value = (sum != 0) ? 32'((e * 65536) / sum) : '0;
        r.kind = 1'b0;
        r.ovf = shadow_ovf;
        r.eor = 1'b0;
        expected_results.push_back(r);
      end
      if (sum >= 65536) begin
        total = shadow_max + ln_sum(sum);
        if (total > INT32_HI) total = INT32_HI;
      end else begin
        total = 0;
      end
      r.value = 32'(total);
      r.kind = 1'b1;
      r.ovf = shadow_ovf;
      r.eor = 1'b1;
      expected_results.push_back(r);
      n_vectors++;
      if (shadow_ovf) n_ovf_vectors++;
      shadow_count = 0;
      shadow_max = INT32_LO;
      shadow_ovf = 1'b0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  task automatic add_score(longint s, logic last);
    score_req_t q;
    if (s > INT32_HI) s = INT32_HI;
    if (s < INT32_LO) s = INT32_LO;
    q.score = 32'(s);
    q.last = last;
    q.pause = 1'b0;
    pending_scores.push_back(q);
  endtask

  task automatic add_pause();
    score_req_t q;
    q.score = '0;
    q.last = 1'b0;
    q.pause = 1'b1;
    pending_scores.push_back(q);
  endtask

  // input acceptance and result checking on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      n_taken++;
      predict_softmax(score_i, final_score_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", result_value_o, '0);
      end else begin
        softmax_res_t w;
        w = expected_results.pop_front();
        if (result_value_o !== w.value) report("value", result_value_o, w.value);
        if (result_kind_o !== w.kind) begin
          report("kind", 32'(result_kind_o), 32'(w.kind));
        end
        if (vector_overflowed_o !== w.ovf) begin
          report("overflow", 32'(vector_overflowed_o), 32'(w.ovf));
        end
        if (end_of_run_o !== w.eor) begin
          report("end_of_run", 32'(end_of_run_o), 32'(w.eor));
        end
      end
      n_results++;
    end
  end

  // request driver: bursts with random gaps, holds payload while stalled
  always @(negedge clk_i) begin
    logic v;
    score_req_t q;
    if (rst_ni) begin
      v = in_valid_i;
      if (!(in_valid_i && n_taken < n_offered)) begin
        v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_scores.size() != 0) begin
          if (pending_scores[0].pause) begin
            if (expected_results.size() == 0) void'(pending_scores.pop_front());
          end else begin
            q = pending_scores.pop_front();
            score_i <= q.score;
            final_score_i <= q.last;
            v = 1'b1;
            n_offered++;
            burst_left--;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
      in_valid_i <= v;
    end
  end

  // result receiver: own stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    logic s;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (!held && n_results >= 40) begin
        held = 1'b1;
        hold_left = 3000;
        s = 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          run_left = run_stall ? $urandom_range(1, 8) : $urandom_range(1, 40);
        end
        run_left--;
        s = run_stall;
      end
      out_stall_i <= s;
    end
  end

  initial begin
    int unsigned len, n_long;
    longint base;
    // directed vectors
    add_score(INT32_HI, 1'b0);
    add_score(INT32_LO, 1'b1);
    add_score(0, 1'b1);
    add_score(0, 1'b0);
    add_score(-EXP_CUTOFF, 1'b0);
    add_score(-EXP_CUTOFF + 1, 1'b1);
    for (int i = 0; i < 4; i++) add_score(INT32_HI, i == 3);   // saturated total
    add_score(INT32_LO, 1'b0);
    add_score(INT32_LO, 1'b1);
    add_score(5 <<< 16, 1'b0);
    add_score(-(3 <<< 16) + 12345, 1'b0);
    add_score(32'h5555_5555, 1'b1);
    add_pause();
    // one vector over capacity; scores past capacity are dropped, the final flag still ends it
    for (int i = 0; i < CAP + 2; i++) add_score(-i, i == CAP + 1);
    n_long = 1;
    // random vectors: mostly short, close scores; maybe one more over capacity
    while (n_offered + pending_scores.size() < 100) begin
      if (n_long < 2 && pending_scores.size() + CAP + 4 < 100 &&
          $urandom_range(0, 7) == 0) begin
        len = CAP + $urandom_range(1, 4);
        n_long++;
      end else begin
        len = $urandom_range(1, 6);
      end
      base = longint'($signed($urandom()));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) add_score(longint'($signed($urandom())), i == len - 1);
        else add_score(base - longint'($urandom_range(0, 16 << 16)), i == len - 1);
      end
      if ($urandom_range(0, 5) == 0) add_pause();
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_scores.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d scores in %0d vectors, %0d over capacity, %0d results checked",
             n_taken, n_vectors, n_ovf_vectors, n_results);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/smlse_pkg.sv
sv/smlse_mul60.sv
sv/smlse_div.sv
sv/softmax_log_sum_exp.sv
verif/softmax_log_sum_exp_test.sv
